// File: design/kms_pkg.sv
// Shared types and constants for the KMP stream matcher.
`timescale 1ns / 1ps

package kms_pkg;

    localparam int PATTERN_MAX   = 64;
    localparam int POSITION_BITS = 20;
    localparam int ADDR_W        = $clog2(PATTERN_MAX);
    localparam int LEN_W         = $clog2(PATTERN_MAX + 1);
    localparam int START_W       = 21;

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    localparam logic [1:0] ST_SEARCH  = 2'd0;
    localparam logic [1:0] ST_FOUND   = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;
    localparam logic [1:0] ST_ALREADY = 2'd3;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       first;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [START_W-1:0] start_position;
    } t_out;

    typedef struct packed {
        logic              pat_we;
        logic [ADDR_W-1:0] pat_waddr;
        logic [7:0]        pat_wdata;
        logic [ADDR_W-1:0] pat_raddr;
        logic              fail_we;
        logic [ADDR_W-1:0] fail_waddr;
        logic [LEN_W-1:0]  fail_wdata;
        logic [ADDR_W-1:0] fail_raddr;
    } t_mem_ctrl;

    typedef struct packed {
        logic valid;
        t_out data;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

endpackage

// File: design/kms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/kms_seq.sv
// Sequencer: pattern load, failure-table build and text search over the RAMs.
`timescale 1ns / 1ps

module kms_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  kms_pkg::t_in              i_in,
    output logic                      o_busy,
    input  logic                      i_out_blocked,
    output kms_pkg::t_mem_ctrl        o_mem,
    input  logic [7:0]                i_pat_q,
    input  logic [kms_pkg::LEN_W-1:0] i_fail_q,
    output kms_pkg::t_res             o_res
);

    localparam int LW = kms_pkg::LEN_W;
    localparam int AW = kms_pkg::ADDR_W;
    localparam int PW = kms_pkg::POSITION_BITS;
    localparam int SW = kms_pkg::START_W;

    kms_pkg::t_state r_state, n_state;
    logic [LW-1:0]   r_k, n_k;
    logic [LW-1:0]   r_plen, n_plen;
    logic [LW-1:0]   r_pb, n_pb;
    logic [LW-1:0]   r_match, n_match;
    logic [PW-1:0]   r_pos, n_pos;
    logic            r_found, n_found;
    logic            r_skip, n_skip;
    logic            r_mode;
    logic [7:0]      r_c;
    logic            r_last;

    logic          accept;
    logic [LW-1:0] pat_i;
    logic [LW-1:0] text_j0;
    logic          pat_full;
    logic          eq;
    logic          walk_more;
    logic          fin;
    logic [LW-1:0] k_fin;
    logic [LW-1:0] raddr;
    logic [LW-1:0] raddr_m1;
    logic [PW-1:0] pos_inc;
    logic          hit;
    logic [SW-1:0] start_old;
    logic [SW-1:0] start_new;

    assign accept   = i_in_valid && (r_state == kms_pkg::S_IDLE);
    assign pat_i    = i_in.first ? '0 : r_plen;
    assign text_j0  = i_in.first ? '0 : r_match;
    assign pat_full = (pat_i >= LW'(kms_pkg::PATTERN_MAX));
    assign eq       = (i_pat_q == r_c);
    assign walk_more = (r_state == kms_pkg::S_WALK) && !r_skip && (r_k != '0) && !eq;
    assign fin = (r_state == kms_pkg::S_WALK) && !walk_more
                 && ((r_mode == kms_pkg::MODE_PATTERN) || !i_out_blocked);
    assign k_fin   = r_k + LW'(eq);
    assign pos_inc = (r_pos == {PW{1'b1}}) ? r_pos : r_pos + PW'(1);
    assign hit     = (r_plen != '0) && (k_fin >= r_plen);

    // 1-based start: position of last matched byte + 1 - pattern length
    assign start_old = SW'(r_pos) + SW'(1) - SW'(r_plen);
    assign start_new = SW'(pos_inc) + SW'(1) - SW'(r_plen);

    always_comb begin
        if (r_state == kms_pkg::S_IDLE) begin
            raddr = (i_in.mode == kms_pkg::MODE_PATTERN) ? r_pb : text_j0;
        end else begin
            raddr = walk_more ? i_fail_q : r_k;
        end
        raddr_m1 = raddr - LW'(1);
    end

    always_comb begin
        o_mem.pat_we     = accept && (i_in.mode == kms_pkg::MODE_PATTERN) && !pat_full;
        o_mem.pat_waddr  = pat_i[AW-1:0];
        o_mem.pat_wdata  = i_in.data_byte;
        o_mem.pat_raddr  = raddr[AW-1:0];
        o_mem.fail_raddr = raddr_m1[AW-1:0];
        if (r_state == kms_pkg::S_IDLE) begin
            o_mem.fail_we    = o_mem.pat_we && (pat_i == '0);
            o_mem.fail_waddr = '0;
            o_mem.fail_wdata = '0;
        end else begin
            o_mem.fail_we    = fin && (r_mode == kms_pkg::MODE_PATTERN);
            o_mem.fail_waddr = r_plen[AW-1:0];
            o_mem.fail_wdata = k_fin;
        end
    end

    always_comb begin
        o_res.valid = fin && (r_mode == kms_pkg::MODE_TEXT);
        if (r_found) begin
            o_res.data.status         = kms_pkg::ST_ALREADY;
            o_res.data.start_position = start_old;
        end else if (hit) begin
            o_res.data.status         = kms_pkg::ST_FOUND;
            o_res.data.start_position = start_new;
        end else begin
            o_res.data.status         = r_last ? kms_pkg::ST_NOMATCH : kms_pkg::ST_SEARCH;
            o_res.data.start_position = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_plen  = r_plen;
        n_pb    = r_pb;
        n_match = r_match;
        n_pos   = r_pos;
        n_found = r_found;
        n_skip  = r_skip;
        case (r_state)
            kms_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_in.mode == kms_pkg::MODE_PATTERN) begin
                        n_match = '0;
                        n_pos   = '0;
                        n_found = 1'b0;
                        n_skip  = 1'b0;
                        if (i_in.first) begin
                            n_plen = '0;
                            n_pb   = '0;
                        end
                        if (!pat_full) begin
                            if (pat_i == '0) begin
                                n_plen = LW'(1);
                                n_pb   = '0;
                            end else begin
                                n_k     = r_pb;
                                n_state = kms_pkg::S_WALK;
                            end
                        end
                    end else begin
                        if (i_in.first) begin
                            n_match = '0;
                            n_pos   = '0;
                            n_found = 1'b0;
                        end
                        n_skip  = (!i_in.first && r_found) || (r_plen == '0);
                        n_k     = text_j0;
                        n_state = kms_pkg::S_WALK;
                    end
                end
            end
            kms_pkg::S_WALK: begin
                if (walk_more) begin
                    n_k = i_fail_q;
                end else if (fin) begin
                    n_state = kms_pkg::S_IDLE;
                    if (r_mode == kms_pkg::MODE_PATTERN) begin
                        n_pb   = k_fin;
                        n_plen = r_plen + LW'(1);
                    end else if (!r_found) begin
                        n_pos = pos_inc;
                        if (r_plen != '0) begin
                            n_match = k_fin;
                            n_found = hit;
                        end
                    end
                end
            end
            default: begin
                n_state = kms_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kms_pkg::S_IDLE;
            r_k     <= '0;
            r_plen  <= '0;
            r_pb    <= '0;
            r_match <= '0;
            r_pos   <= '0;
            r_found <= 1'b0;
            r_skip  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_plen  <= n_plen;
            r_pb    <= n_pb;
            r_match <= n_match;
            r_pos   <= n_pos;
            r_found <= n_found;
            r_skip  <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_in.mode;
            r_c    <= i_in.data_byte;
            r_last <= i_in.last;
        end
    end

    assign o_busy = (r_state != kms_pkg::S_IDLE);

endmodule

// File: design/kmp_stream_matcher.sv
// KMP stream matcher: pattern load, failure-table build, first-occurrence search.
// Text byte: taken in S_IDLE, then S_WALK follows the failure chain; next byte waits for the walk.
// Pattern byte: the first byte or one past the store needs no walk, else S_WALK as for text.
// The chain walk reads pattern and failure RAMs once per cycle; one byte in flight.
// Result sits in an output register, so a new byte is taken while it waits.
// Sync reset clears control state only; RAM contents stay undefined, no clearing pass.
`timescale 1ns / 1ps

module kmp_stream_matcher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  kms_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output kms_pkg::t_out o_out
);

    kms_pkg::t_mem_ctrl        mem;
    kms_pkg::t_res             res;
    logic [7:0]                pat_q;
    logic [kms_pkg::LEN_W-1:0] fail_q;
    logic                      busy;
    logic                      out_blocked;

    logic          r_out_valid;
    kms_pkg::t_out r_out;

    assign out_blocked = r_out_valid && i_out_stall;

    kms_ram #(
        .WIDTH(8),
        .DEPTH(kms_pkg::PATTERN_MAX)
    ) u_pat_ram (
        .i_clk  (i_clk),
        .i_we   (mem.pat_we),
        .i_waddr(mem.pat_waddr),
        .i_wdata(mem.pat_wdata),
        .i_raddr(mem.pat_raddr),
        .o_rdata(pat_q)
    );

    kms_ram #(
        .WIDTH(kms_pkg::LEN_W),
        .DEPTH(kms_pkg::PATTERN_MAX)
    ) u_fail_ram (
        .i_clk  (i_clk),
        .i_we   (mem.fail_we),
        .i_waddr(mem.fail_waddr),
        .i_wdata(mem.fail_wdata),
        .i_raddr(mem.fail_raddr),
        .o_rdata(fail_q)
    );

    kms_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in         (i_in),
        .o_busy       (busy),
        .i_out_blocked(out_blocked),
        .o_mem        (mem),
        .i_pat_q      (pat_q),
        .i_fail_q     (fail_q),
        .o_res        (res)
    );

    // sequencer only finishes a text byte when this register can take the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out <= res.data;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: sim/tb_kmp_stream_matcher.sv
// Self-checking testbench for the KMP stream matcher: directed and random pattern/text beats vs a predictor.
`timescale 1ns / 1ps

module tb_kmp_stream_matcher;
    import kms_pkg::*;

    localparam int DIRECTED_BEATS = 25;
    localparam int RANDOM_BEATS   = 1350;
    localparam int TAIL_BEATS     = 150;
    localparam int HOLD_CYCLES    = 80;
    localparam int HOLD_BEATS     = 24;
    localparam int SETTLE_CYCLES  = 20;
    localparam longint unsigned POS_LIMIT = (longint'(1) << POSITION_BITS) - 1;

    // Tracks pattern, failure links and search progress; queues the status each text beat gives.
    class match_scoreboard;
        logic [7:0]        pat_bytes [PATTERN_MAX];
        int unsigned       fail_links [PATTERN_MAX];
        int unsigned       pat_len;
        int unsigned       border_len;
        int unsigned       matched;
        longint unsigned   text_pos;
        bit                found;
        t_out              status_q [$];
        int unsigned       fail_count;

        function new();
            pat_len    = 0;
            border_len = 0;
            matched    = 0;
            text_pos   = 0;
            found      = 1'b0;
            fail_count = 0;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function logic [START_W-1:0] first_start();
            return START_W'(text_pos + 1 - pat_len);
        endfunction

        function void note_beat(t_in beat);
            int unsigned k;
            int unsigned slot;
            t_out res;
            if (beat.mode == MODE_PATTERN) begin
                if (beat.first) begin
                    pat_len    = 0;
                    border_len = 0;
                end
                matched  = 0;
                text_pos = 0;
                found    = 1'b0;
                // bytes past the store are dropped, pattern stays truncated
                if (pat_len >= PATTERN_MAX)
                    return;
                slot = pat_len;
                pat_bytes[slot] = beat.data_byte;
                if (slot == 0) begin
                    fail_links[0] = 0;
                    border_len    = 0;
                end else begin
                    k = border_len;
                    while (k > 0 && pat_bytes[k] != beat.data_byte)
                        k = fail_links[k-1];
                    if (pat_bytes[k] == beat.data_byte)
                        k++;
                    fail_links[slot] = k;
                    border_len       = k;
                end
                pat_len = slot + 1;
                return;
            end

            if (beat.first) begin
                matched  = 0;
                text_pos = 0;
                found    = 1'b0;
            end
            if (found) begin
                res.status         = ST_ALREADY;
                res.start_position = first_start();
                status_q.push_back(res);
                return;
            end
            if (text_pos < POS_LIMIT)
                text_pos++;
            res.status         = beat.last ? ST_NOMATCH : ST_SEARCH;
            res.start_position = '0;
            if (pat_len != 0) begin
                k = matched;
                while (k > 0 && pat_bytes[k] != beat.data_byte)
                    k = fail_links[k-1];
                if (pat_bytes[k] == beat.data_byte)
                    k++;
                matched = k;
                if (k >= pat_len) begin
                    found              = 1'b1;
                    res.status         = ST_FOUND;
                    res.start_position = first_start();
                end
            end
            status_q.push_back(res);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (status_q.size() == 0) begin
                $error("unexpected result beat: status %0d, start_position %0d",
                       got.status, got.start_position);
                fail_count++;
                return;
            end
            want = status_q.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                fail_count++;
            end
            if (got.start_position !== want.start_position) begin
                $error("start_position: expected %0d, actual %0d",
                       want.start_position, got.start_position);
                fail_count++;
            end
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_beat   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_beat;

    match_scoreboard sb = new();

    int         idle_odds   = 4;   // 0 = no idling on either side
    int         holds_asked = 0;
    int         holds_done  = 0;
    int         sent_count  = 0;
    logic [7:0] letters [4];
    int         n_letters   = 2;
    bit         any_byte    = 1'b0;

    kmp_stream_matcher uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("kmp_stream_matcher verification failed");
        $finish;
    end

    function automatic t_in make_beat(logic mode, logic [7:0] b, logic f, logic l);
        t_in beat;
        beat.mode      = mode;
        beat.data_byte = b;
        beat.first     = f;
        beat.last      = l;
        return beat;
    endfunction

    function automatic logic [7:0] pick_byte();
        if (any_byte)
            return 8'($urandom_range(0, 255));
        return letters[$urandom_range(0, n_letters - 1)];
    endfunction

    // Leaves valid high after the beat is taken; the next call or a gap decides what follows.
    task automatic send_beat(t_in beat);
        // no idling once the tail of the run is reached
        if (sent_count >= DIRECTED_BEATS + RANDOM_BEATS - TAIL_BEATS)
            idle_odds = 0;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_beat(beat);
        sent_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Result side: check accepted beats, then pick the stall for the next cycle.
    initial begin : result_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(out_beat);
            if (holds_done != holds_asked) begin
                holds_done++;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        t_in        directed [DIRECTED_BEATS];
        logic [7:0] pat_copy [$];
        logic [7:0] text_bytes [$];
        logic [7:0] b;
        int         plen;
        int         at;
        int         round;
        bit         resume;

        directed = '{
            // no pattern loaded yet: never matches
            make_beat(MODE_TEXT,    8'h00, 1'b1, 1'b0),
            make_beat(MODE_TEXT,    8'hFF, 1'b0, 1'b1),
            make_beat(MODE_PATTERN, 8'h00, 1'b1, 1'b1),
            make_beat(MODE_PATTERN, 8'hFF, 1'b0, 1'b0),
            make_beat(MODE_TEXT,    8'hFF, 1'b1, 1'b0),
            make_beat(MODE_TEXT,    8'h00, 1'b0, 1'b0),
            make_beat(MODE_TEXT,    8'hFF, 1'b0, 1'b0),
            // last on an already found text, then bytes past last
            make_beat(MODE_TEXT,    8'h55, 1'b0, 1'b1),
            make_beat(MODE_TEXT,    8'hAA, 1'b0, 1'b0),
            make_beat(MODE_TEXT,    8'h01, 1'b1, 1'b0),
            make_beat(MODE_TEXT,    8'h02, 1'b0, 1'b1),
            make_beat(MODE_TEXT,    8'h00, 1'b0, 1'b0),
            make_beat(MODE_TEXT,    8'hFF, 1'b0, 1'b0),
            // appending to the pattern restarts the search
            make_beat(MODE_PATTERN, 8'h00, 1'b0, 1'b0),
            make_beat(MODE_TEXT,    8'h00, 1'b0, 1'b0),
            make_beat(MODE_TEXT,    8'hFF, 1'b0, 1'b0),
            make_beat(MODE_TEXT,    8'h00, 1'b0, 1'b0),
            // "aab" needs the failure chain on "aaab"
            make_beat(MODE_PATTERN, 8'h61, 1'b1, 1'b0),
            make_beat(MODE_PATTERN, 8'h61, 1'b0, 1'b1),
            make_beat(MODE_PATTERN, 8'h62, 1'b0, 1'b0),
            make_beat(MODE_TEXT,    8'h61, 1'b1, 1'b0),
            make_beat(MODE_TEXT,    8'h61, 1'b0, 1'b0),
            make_beat(MODE_TEXT,    8'h61, 1'b0, 1'b0),
            make_beat(MODE_TEXT,    8'h62, 1'b0, 1'b0),
            make_beat(MODE_TEXT,    8'h62, 1'b0, 1'b1)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_beat(directed[i]);

        round = 0;
        while (sent_count < DIRECTED_BEATS + RANDOM_BEATS) begin
            round++;
            if (sent_count >= DIRECTED_BEATS + RANDOM_BEATS - TAIL_BEATS)
                idle_odds = 0;
            else
                case ($urandom_range(0, 2))
                    0:       idle_odds = 0;
                    1:       idle_odds = 3;
                    default: idle_odds = 8;
                endcase

            if (round == 9)
                drain_results();

            if (round == 1 || $urandom_range(0, 3) == 0) begin
                n_letters = $urandom_range(2, 4);
                foreach (letters[i])
                    letters[i] = 8'($urandom_range(0, 255));
                any_byte = ($urandom_range(0, 4) == 0);
                // first pattern runs past the store to cover truncation
                if (round == 1)
                    plen = PATTERN_MAX + 2;
                else
                    case ($urandom_range(0, 19))
                        0:       plen = $urandom_range(PATTERN_MAX - 4, PATTERN_MAX + 6);
                        1, 2:    plen = $urandom_range(6, 20);
                        default: plen = $urandom_range(1, 5);
                    endcase
                pat_copy.delete();
                for (int j = 0; j < plen; j++) begin
                    b = pick_byte();
                    send_beat(make_beat(MODE_PATTERN, b, j == 0, 1'($urandom_range(0, 1))));
                    if (pat_copy.size() < PATTERN_MAX)
                        pat_copy.push_back(b);
                end
            end

            // long receiver hold while text keeps coming: block must back up
            if (round == 4) begin
                holds_asked++;
                repeat (HOLD_BEATS)
                    send_beat(make_beat(MODE_TEXT, pick_byte(), 1'b0, 1'b0));
            end

            text_bytes.delete();
            repeat ($urandom_range(1, 30))
                text_bytes.push_back(pick_byte());
            if (pat_copy.size() != 0 && $urandom_range(0, 1) == 1) begin
                at = $urandom_range(0, text_bytes.size());
                foreach (pat_copy[i])
                    text_bytes.insert(at + i, pat_copy[i]);
            end
            resume = ($urandom_range(0, 9) == 0);
            foreach (text_bytes[i]) begin
                if (i == 2 && $urandom_range(0, 19) == 0) begin
                    b = pick_byte();
                    send_beat(make_beat(MODE_PATTERN, b, 1'b0, 1'($urandom_range(0, 1))));
                    if (pat_copy.size() < PATTERN_MAX)
                        pat_copy.push_back(b);
                end
                send_beat(make_beat(MODE_TEXT, text_bytes[i], i == 0 && !resume,
                                    (i == text_bytes.size() - 1) ?
                                        ($urandom_range(0, 4) != 0) :
                                        ($urandom_range(0, 29) == 0)));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("kmp_stream_matcher verification clean");
        else
            $display("kmp_stream_matcher verification failed");
        $finish;
    end

endmodule
